>>> rtl/core/fqm_pkg.sv
// Package for the FIFO queued mutex: field widths, operation and status codes,
// and the control state type. No dependencies.
package fqm_pkg;

  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned TID_W    = 6;
  localparam int unsigned STATUS_W = 4;
  localparam int unsigned NEST_W   = 8;
  localparam int unsigned WCOUNT_W = 7;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_GRAB       = 3'd0,
    FUNC_TRY_GRAB   = 3'd1,
    FUNC_RELEASE    = 3'd2,
    FUNC_ROTATE     = 3'd3,
    FUNC_REL_UNCONT = 3'd4
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_GRANTED       = 4'd0,
    STAT_QUEUED        = 4'd1,
    STAT_BUSY          = 4'd2,
    STAT_RELEASED      = 4'd3,
    STAT_NESTED        = 4'd4,
    STAT_KEPT          = 4'd5,
    STAT_REFUSED       = 4'd6,
    STAT_NOT_OWNER     = 4'd7,
    STAT_SELF_DEADLOCK = 4'd8,
    STAT_QUEUE_FULL    = 4'd9,
    STAT_DEPTH_SAT     = 4'd10
  } status_e;

  typedef enum logic {
    CTRL_IDLE = 1'b0,
    CTRL_EXEC = 1'b1
  } ctrl_state_e;

endpackage

>>> rtl/core/fqm_req_if.sv
// Request channel of the FIFO queued mutex: operation code and thread id.
// Depends on fqm_pkg.
interface fqm_req_if;
  import fqm_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [TID_W-1:0]  thread_id;

  modport source (output valid, output func, output thread_id, input ready);
  modport sink   (input valid, input func, input thread_id, output ready);
endinterface

>>> rtl/core/fqm_rsp_if.sv
// Response channel of the FIFO queued mutex: status and lock state after a request.
// Depends on fqm_pkg.
interface fqm_rsp_if;
  import fqm_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                owner_valid;
  logic [TID_W-1:0]    owner_thread;
  logic [NEST_W-1:0]   nest_depth;
  logic [WCOUNT_W-1:0] waiter_count;
  logic                wake_valid;
  logic [TID_W-1:0]    wake_thread;

  modport source (output valid, output status, output owner_valid, output owner_thread,
                  output nest_depth, output waiter_count, output wake_valid,
                  output wake_thread, input ready);
  modport sink   (input valid, input status, input owner_valid, input owner_thread,
                  input nest_depth, input waiter_count, input wake_valid,
                  input wake_thread, output ready);
endinterface

>>> rtl/core/fqm_cfg_if.sv
// Configuration write channel of the FIFO queued mutex: the recursive mode bit.
// No dependencies.
interface fqm_cfg_if;
  logic valid;
  logic ready;
  logic recursive_mode;

  modport source (output valid, output recursive_mode, input ready);
  modport sink   (input valid, input recursive_mode, output ready);
endinterface

>>> rtl/core/fqm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module fqm_ram #(
  parameter int unsigned WIDTH = 6,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // Hold read data until the next read
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/fifo_queued_mutex.sv
// Top level of the FIFO queued mutex: owner registers, waiter FIFO in a RAM,
// request sequencer and response register. Depends on fqm_pkg, the fqm_*_if
// interfaces and fqm_ram.
//
//   channel  modport  direction  transaction carries
//   req_i    sink     in         func, thread_id
//   rsp_o    source   out        status, owner_valid, owner_thread, nest_depth,
//                                waiter_count, wake_valid, wake_thread
//   cfg_i    sink     in         recursive_mode (always ready)
//
// Each request has an accept and an execute cycle, split by the registered RAM read:
// the accept cycle issues a read of the FIFO head entry, and the execute cycle uses
// that registered read data, updates the owner and queue registers, writes the tail
// entry if a thread is queued, and loads the response register (req_i is not ready then).
// The response register parts the two sides: a new request is accepted while an
// earlier response still waits; the execute cycle holds while it is not taken.
// Reset clears the owner and queue pointers at once; the waiter RAM is not cleared,
// since only entries that were written are ever used.
module fifo_queued_mutex #(
  parameter int unsigned THREADS   = 64,
  parameter int unsigned DEPTH_MAX = 255
) (
  input  logic clk_i,
  input  logic rst_ni,
  fqm_req_if.sink   req_i,
  fqm_rsp_if.source rsp_o,
  fqm_cfg_if.sink   cfg_i
);
  import fqm_pkg::*;

  localparam int unsigned PTR_W   = $clog2(THREADS);
  localparam int unsigned CNT_W   = $clog2(THREADS + 1);
  localparam int unsigned DEPTH_W = $clog2(DEPTH_MAX + 1);

  localparam logic [PTR_W-1:0]   LastSlot  = PTR_W'(THREADS - 1);
  localparam logic [CNT_W-1:0]   QueueMax  = CNT_W'(THREADS);
  localparam logic [DEPTH_W-1:0] DepthTop  = DEPTH_W'(DEPTH_MAX);
  localparam logic [DEPTH_W-1:0] DepthOne  = DEPTH_W'(1);

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    return (p == LastSlot) ? '0 : p + PTR_W'(1);
  endfunction

  // Control and lock state
  ctrl_state_e         state_q, state_d;
  logic                mode_q;
  logic                held_q, held_d;
  logic [TID_W-1:0]    owner_q, owner_d;
  logic [DEPTH_W-1:0]  depth_q, depth_d;
  logic [PTR_W-1:0]    head_q, head_d;
  logic [PTR_W-1:0]    tail_q, tail_d;
  logic [CNT_W-1:0]    count_q, count_d;

  // Request being executed
  logic [FUNC_W-1:0]   func_q;
  logic [TID_W-1:0]    tid_q;

  // Response register
  logic                rsp_valid_q;
  status_e             status_q, status_d;
  logic                own_v_q;
  logic [TID_W-1:0]    own_t_q, own_t_d;
  logic [NEST_W-1:0]   nest_q, nest_d;
  logic [WCOUNT_W-1:0] wcnt_q, wcnt_d;
  logic                wake_q, wake_d;
  logic [TID_W-1:0]    wake_t_q, wake_t_d;

  logic                req_accept;
  logic                rsp_free;
  logic                commit;
  logic                owned;
  logic                rec;
  logic                do_pop;
  logic                do_push;
  logic [TID_W-1:0]    head_tid;
  logic [DEPTH_W+NEST_W-1:0] depth_ext;
  logic [CNT_W+WCOUNT_W-1:0] count_ext;

  assign req_i.ready = (state_q == CTRL_IDLE);
  assign req_accept  = req_i.valid && req_i.ready;
  assign rsp_free    = !rsp_valid_q || rsp_o.ready;
  assign commit      = (state_q == CTRL_EXEC) && rsp_free;
  assign cfg_i.ready = 1'b1;

  // Waiter FIFO storage; read the head on accept, write the tail on commit
  fqm_ram #(
    .WIDTH (TID_W),
    .DEPTH (THREADS)
  ) u_wait_ram (
    .clk_i   (clk_i),
    .we_i    (commit && do_push),
    .waddr_i (tail_q),
    .wdata_i (tid_q),
    .re_i    (req_accept),
    .raddr_i (head_q),
    .rdata_o (head_tid)
  );

  assign owned = held_q && (owner_q == tid_q);
  assign rec   = mode_q;

  always_comb begin
    state_d  = state_q;
    held_d   = held_q;
    owner_d  = owner_q;
    depth_d  = depth_q;
    status_d = STAT_REFUSED;
    do_pop   = 1'b0;
    do_push  = 1'b0;
    wake_d   = 1'b0;
    wake_t_d = '0;

    unique case (state_q)
      CTRL_IDLE: begin
        if (req_accept) begin
          state_d = CTRL_EXEC;
        end
      end
      CTRL_EXEC: begin
        if (rsp_free) begin
          state_d = CTRL_IDLE;
        end
      end
      default: state_d = CTRL_IDLE;
    endcase

    unique case (func_q)
      FUNC_GRAB, FUNC_TRY_GRAB: begin
        if (owned) begin
          if (!rec) begin
            status_d = (func_q == FUNC_GRAB) ? STAT_SELF_DEADLOCK : STAT_BUSY;
          end else if (depth_q >= DepthTop) begin
            status_d = STAT_DEPTH_SAT;
          end else begin
            depth_d  = depth_q + DepthOne;
            status_d = STAT_GRANTED;
          end
        end else if (!held_q) begin
          held_d   = 1'b1;
          owner_d  = tid_q;
          depth_d  = DepthOne;
          status_d = STAT_GRANTED;
        end else if (func_q == FUNC_TRY_GRAB) begin
          status_d = STAT_BUSY;
        end else if (count_q >= QueueMax) begin
          status_d = STAT_QUEUE_FULL;
        end else begin
          do_push  = 1'b1;
          status_d = STAT_QUEUED;
        end
      end
      FUNC_RELEASE: begin
        if (!owned) begin
          status_d = STAT_NOT_OWNER;
        end else if (rec && (depth_q > DepthOne)) begin
          depth_d  = depth_q - DepthOne;
          status_d = STAT_NESTED;
        end else begin
          do_pop   = (count_q != '0);
          status_d = STAT_RELEASED;
        end
      end
      FUNC_ROTATE: begin
        if (!owned) begin
          status_d = STAT_NOT_OWNER;
        end else if ((count_q == '0) || (rec && (depth_q > DepthOne))) begin
          status_d = STAT_KEPT;
        end else begin
          do_pop   = 1'b1;
          do_push  = 1'b1;
          status_d = STAT_QUEUED;
        end
      end
      FUNC_REL_UNCONT: begin
        if (!owned) begin
          status_d = STAT_NOT_OWNER;
        end else if ((rec && (depth_q != DepthOne)) || (count_q != '0)) begin
          status_d = STAT_REFUSED;
        end else begin
          held_d   = 1'b0;
          owner_d  = '0;
          depth_d  = '0;
          status_d = STAT_RELEASED;
        end
      end
      default: status_d = STAT_REFUSED;
    endcase

    // Full release: hand the lock to the FIFO head, or free it when nobody waits
    if ((func_q == FUNC_RELEASE) && (status_d == STAT_RELEASED) && !do_pop) begin
      held_d  = 1'b0;
      owner_d = '0;
      depth_d = '0;
    end
    if (do_pop) begin
      held_d   = 1'b1;
      owner_d  = head_tid;
      depth_d  = DepthOne;
      wake_d   = 1'b1;
      wake_t_d = head_tid;
    end

    head_d  = do_pop  ? next_slot(head_q) : head_q;
    tail_d  = do_push ? next_slot(tail_q) : tail_q;
    count_d = count_q + CNT_W'(do_push) - CNT_W'(do_pop);

    depth_ext = {{NEST_W{1'b0}}, depth_d};
    count_ext = {{WCOUNT_W{1'b0}}, count_d};
    own_t_d   = held_d ? owner_d : '0;
    nest_d    = held_d ? depth_ext[NEST_W-1:0] : '0;
    wcnt_d    = count_ext[WCOUNT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CTRL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Mode register; read when a request executes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_i.valid) begin
      mode_q <= cfg_i.recursive_mode;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= 1'b0;
      owner_q <= '0;
      depth_q <= '0;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else if (commit) begin
      held_q  <= held_d;
      owner_q <= owner_d;
      depth_q <= depth_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // Capture the request on accept
  always_ff @(posedge clk_i) begin
    if (req_accept) begin
      func_q <= req_i.func;
      tid_q  <= req_i.thread_id;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (commit) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      status_q <= status_d;
      own_v_q  <= held_d;
      own_t_q  <= own_t_d;
      nest_q   <= nest_d;
      wcnt_q   <= wcnt_d;
      wake_q   <= wake_d;
      wake_t_q <= wake_t_d;
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.status       = status_q;
  assign rsp_o.owner_valid  = own_v_q;
  assign rsp_o.owner_thread = own_t_q;
  assign rsp_o.nest_depth   = nest_q;
  assign rsp_o.waiter_count = wcnt_q;
  assign rsp_o.wake_valid   = wake_q;
  assign rsp_o.wake_thread  = wake_t_q;

endmodule

>>> rtl/core/fqm_checker.sv
// Port-level checks for the FIFO queued mutex response channel, and the bind
// that attaches them to the top level. Depends on fqm_pkg.
module fqm_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         rsp_valid_i,
  input logic                         rsp_ready_i,
  input logic [fqm_pkg::STATUS_W-1:0] status_i,
  input logic                         owner_valid_i,
  input logic [fqm_pkg::TID_W-1:0]    owner_thread_i,
  input logic [fqm_pkg::NEST_W-1:0]   nest_depth_i,
  input logic                         wake_valid_i,
  input logic [fqm_pkg::TID_W-1:0]    wake_thread_i
);
  import fqm_pkg::*;

  // Hold a stalled response transaction
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(status_i)
      && $stable(owner_thread_i) && $stable(wake_thread_i))
    else $error("response changed while stalled");

  // A free lock reports no owner and no depth
  a_free_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !owner_valid_i |-> (owner_thread_i == '0) && (nest_depth_i == '0))
    else $error("free lock reports an owner or depth");

  // A woken thread is the new owner at depth one
  a_wake_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && wake_valid_i |-> owner_valid_i && (owner_thread_i == wake_thread_i)
      && (nest_depth_i == NEST_W'(1)))
    else $error("woken thread is not the owner at depth one");

  // Hand-over happens only on a full release or a rotate
  a_wake_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && wake_valid_i |-> (status_i == STAT_RELEASED) || (status_i == STAT_QUEUED))
    else $error("wake reported with an unexpected status");

endmodule

bind fifo_queued_mutex fqm_checker u_fqm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .status_i       (rsp_o.status),
  .owner_valid_i  (rsp_o.owner_valid),
  .owner_thread_i (rsp_o.owner_thread),
  .nest_depth_i   (rsp_o.nest_depth),
  .wake_valid_i   (rsp_o.wake_valid),
  .wake_thread_i  (rsp_o.wake_thread)
);
